FILE: rtl/bb6_pkg.sv
// Shared constants, state encoding and controller/datapath link types for
// the bijective base-6 encoder. No dependencies.
package bb6_pkg;

    localparam int MAX_DIGITS  = 25;
    localparam int VALUE_W     = 64;
    localparam int Q_W         = VALUE_W - 1;
    localparam int DIGIT_W     = 3;
    localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
    localparam int OUT_TDATA_W = 8;

    // Divide-by-six step: padded dividend, bits handled per cycle, division steps per digit
    localparam int DIV_W       = 64;
    localparam int DIV_CHUNK   = 16;
    localparam int DIV_STEPS   = DIV_W / DIV_CHUNK;
    localparam int PHASE_W     = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_EMIT,
        ST_ERR
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        logic step;
        logic emit;
        logic emit_err;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_bad;
        logic q_zero;
        logic cnt_full;
        logic cnt_one;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

FILE: rtl/bijective_base6_encoder.sv
// Bijective base-6 encoder: takes a signed 64-bit value and returns its
// digits (1..6), most significant first, one item per digit, the final one
// marked by tlast. A value of zero or below yields a single item with tuser
// set, digit 0 and tlast set. An item whose numeral has n digits (at most
// 25) is accepted, then per digit the quotient is decremented and divided
// by six over the division steps (two bytes of long division a cycle);
// once the quotient is seen to reach zero, the digits are handed out one
// per cycle from the digit stack while the output is not stalled. The
// next item is accepted while the last result still waits in the output
// register.
// Depends on bb6_pkg, bb6_ctrl and bb6_dpath.
module bijective_base6_encoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [bb6_pkg::VALUE_W-1:0]       i_s_axis_tdata,   // [63:0] value
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [bb6_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,   // [2:0] digit, rest zero
    output logic                              o_m_axis_tuser,   // [0] bad_input
    output logic                              o_m_axis_tlast
);

    bb6_pkg::t_cmd               cmd;
    bb6_pkg::t_stat              stat;
    logic [bb6_pkg::DIGIT_W-1:0] digit;

    bb6_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bb6_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (o_m_axis_tvalid),
        .o_digit     (digit),
        .o_bad       (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = bb6_pkg::OUT_TDATA_W'(digit);

endmodule

FILE: rtl/bb6_ctrl.sv
// Sequencer for the bijective base-6 encoder: accepts an item, runs the
// digit loop, then hands out results. Depends on bb6_pkg.
module bb6_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bb6_pkg::t_stat i_stat,
    output bb6_pkg::t_cmd  o_cmd
);

    bb6_pkg::t_state r_state;
    bb6_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bb6_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bb6_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.in_bad ? bb6_pkg::ST_ERR : bb6_pkg::ST_CALC;
                end
            end
            bb6_pkg::ST_CALC: begin
                priority if (i_stat.q_zero) begin
                    n_state = bb6_pkg::ST_EMIT;
                end else if (i_stat.cnt_full) begin
                    n_state = bb6_pkg::ST_ERR;
                end else begin
                    n_state = bb6_pkg::ST_DIV;
                end
            end
            bb6_pkg::ST_DIV: begin
                if (i_stat.div_last) begin
                    n_state = bb6_pkg::ST_CALC;
                end
            end
            bb6_pkg::ST_EMIT: begin
                if (i_stat.out_free && i_stat.cnt_one) begin
                    n_state = bb6_pkg::ST_IDLE;
                end
            end
            bb6_pkg::ST_ERR: begin
                if (i_stat.out_free) begin
                    n_state = bb6_pkg::ST_IDLE;
                end
            end
            default: n_state = bb6_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = (r_state == bb6_pkg::ST_IDLE);
        o_cmd.load     = (r_state == bb6_pkg::ST_IDLE) && i_in_valid;
        o_cmd.start    = (r_state == bb6_pkg::ST_CALC) && !i_stat.q_zero
                         && !i_stat.cnt_full;
        o_cmd.step     = (r_state == bb6_pkg::ST_DIV);
        o_cmd.emit     = (r_state == bb6_pkg::ST_EMIT) && i_stat.out_free;
        o_cmd.emit_err = (r_state == bb6_pkg::ST_ERR) && i_stat.out_free;
    end

endmodule

FILE: rtl/bb6_dpath.sv
// Datapath of the bijective base-6 encoder: quotient register, multi-cycle
// divide-by-six step, digit stack and output register. Depends on bb6_pkg.
module bb6_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bb6_pkg::t_cmd                 i_cmd,
    input  logic [bb6_pkg::VALUE_W-1:0]   i_in_data,
    input  logic                          i_out_ready,
    output bb6_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [bb6_pkg::DIGIT_W-1:0]   o_digit,
    output logic                          o_bad,
    output logic                          o_last
);

    logic [bb6_pkg::Q_W-1:0]     r_q;
    logic [bb6_pkg::CNT_W-1:0]   r_cnt;
    logic [bb6_pkg::DIGIT_W-1:0] r_stack [bb6_pkg::MAX_DIGITS];
    logic [bb6_pkg::DIV_W-1:0]   r_div;
    logic [2:0]                  r_rem;
    logic [bb6_pkg::PHASE_W-1:0] r_phase;
    logic                        r_out_valid;
    logic [bb6_pkg::DIGIT_W-1:0] r_out_digit;
    logic                        r_out_bad;
    logic                        r_out_last;

    logic [bb6_pkg::DIV_W-1:0]   n_div;
    logic [2:0]                  n_rem;
    logic [bb6_pkg::DIGIT_W-1:0] n_digit;
    logic [10:0]                 res_hi;
    logic [10:0]                 res_lo;
    logic                        div_last;
    logic                        push;

    // One byte of long division by six: remainder in, quotient byte and
    // remainder out. x/6 taken as (x*683)>>12, exact for x below 1536.
    function automatic logic [10:0] f_div6_byte(input logic [2:0] rem,
                                                input logic [7:0] b);
        logic [10:0] x;
        logic [21:0] p;
        logic [7:0]  q;
        logic [10:0] q6;
        logic [10:0] r;
        x  = {rem, b};
        p  = 22'(x) * 22'd683;
        q  = p[19:12];
        q6 = 11'({q, 2'b00}) + 11'({q, 1'b0});
        r  = x - q6;
        return {q, r[2:0]};
    endfunction

    // Two bytes of the long division per cycle, most significant first; the
    // quotient bytes shift in at the bottom as the dividend shifts out the top
    always_comb begin
        res_hi  = f_div6_byte(r_rem, r_div[bb6_pkg::DIV_W-1 -: 8]);
        res_lo  = f_div6_byte(res_hi[2:0], r_div[bb6_pkg::DIV_W-9 -: 8]);
        n_div   = {r_div[bb6_pkg::DIV_W-bb6_pkg::DIV_CHUNK-1:0],
                   res_hi[10:3], res_lo[10:3]};
        n_rem   = res_lo[2:0];
        n_digit = n_rem + 3'd1;
    end

    assign div_last = (r_phase == bb6_pkg::PHASE_W'(bb6_pkg::DIV_STEPS - 1));
    assign push     = i_cmd.step && div_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div   <= '0;
            r_rem   <= '0;
            r_phase <= '0;
        end else if (i_cmd.start) begin
            r_div   <= bb6_pkg::DIV_W'(r_q - bb6_pkg::Q_W'(1));
            r_rem   <= '0;
            r_phase <= '0;
        end else if (i_cmd.step) begin
            r_div   <= n_div;
            r_rem   <= n_rem;
            r_phase <= r_phase + bb6_pkg::PHASE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q   <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            r_q   <= i_in_data[bb6_pkg::Q_W-1:0];
            r_cnt <= '0;
        end else if (push) begin
            r_q   <= n_div[bb6_pkg::Q_W-1:0];
            r_cnt <= r_cnt + bb6_pkg::CNT_W'(1);
        end else if (i_cmd.emit) begin
            r_cnt <= r_cnt - bb6_pkg::CNT_W'(1);
        end else if (i_cmd.emit_err) begin
            r_cnt <= '0;
        end
    end

    // Digit stack: push at the top when a division ends, pop from the top on emit
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[0] <= n_digit;
            for (int i = 1; i < bb6_pkg::MAX_DIGITS; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (i_cmd.emit) begin
            for (int i = 0; i < bb6_pkg::MAX_DIGITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_digit <= r_stack[0];
            r_out_bad   <= 1'b0;
            r_out_last  <= (r_cnt == bb6_pkg::CNT_W'(1));
        end else if (i_cmd.emit_err) begin
            r_out_digit <= '0;
            r_out_bad   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    always_comb begin
        o_stat.in_bad   = i_in_data[bb6_pkg::VALUE_W-1] || (i_in_data == '0);
        o_stat.q_zero   = (r_q == '0);
        o_stat.cnt_full = (r_cnt == bb6_pkg::CNT_W'(bb6_pkg::MAX_DIGITS));
        o_stat.cnt_one  = (r_cnt == bb6_pkg::CNT_W'(1));
        o_stat.div_last = div_last;
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_out_digit;
    assign o_bad       = r_out_bad;
    assign o_last      = r_out_last;

endmodule
